### rtl/core/frrl_pkg.sv
// Package: widths, constants and types for the ramp-limited first-order regulator.
`default_nettype none
package frrl_pkg;

  localparam int DistW     = 16;
  localparam int PosW      = 16;
  localparam int RefW      = 16;
  localparam int GainW     = 18;
  localparam int ErrW      = 18;
  localparam int VelW      = 20;
  localparam int OfsW      = 18;
  localparam int CfgDataW  = 18;
  localparam int CfgIdxW   = 3;
  localparam int ProdW     = VelW + GainW;
  localparam int AccW      = ProdW + 2;
  localparam int GainFrac  = 12;
  localparam int PerFrac   = 16;
  localparam int RampW     = OfsW + 1;
  localparam int PredW     = ProdW - PerFrac + 1;

  // sample period, unsigned Q0.16, carried as a positive signed multiplier operand
  localparam logic signed [GainW-1:0] SamplePeriodQ16 = 18'sd1311;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TARGET_REF  = 3'd0,
    CFG_START_REF   = 3'd1,
    CFG_RAMP_STEP   = 3'd2,
    CFG_GAIN_ERR    = 3'd3,
    CFG_GAIN_PERR   = 3'd4,
    CFG_GAIN_POUT   = 3'd5,
    CFG_POS_UPPER   = 3'd6,
    CFG_POS_LOWER   = 3'd7
  } cfg_idx_e;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_M0   = 9'b000000010,
    S_M1   = 9'b000000100,
    S_M2   = 9'b000001000,
    S_ACC  = 9'b000010000,
    S_SAT  = 9'b000100000,
    S_PH   = 9'b001000000,
    S_PL   = 9'b010000000,
    S_DONE = 9'b100000000
  } state_e;

endpackage
`default_nettype wire

### rtl/core/frrl_in_if.sv
// Interface: input channel carrying one distance/position word.
`default_nettype none
interface frrl_in_if
  import frrl_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [DistW-1:0]       measured_distance;
  logic signed [PosW-1:0] axis_position;

  modport source (output valid, output measured_distance, output axis_position, input ready);
  modport sink   (input valid, input measured_distance, input axis_position, output ready);
endinterface
`default_nettype wire

### rtl/core/frrl_out_if.sv
// Interface: output channel carrying one velocity command word.
`default_nettype none
interface frrl_out_if
  import frrl_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic signed [VelW-1:0] velocity_command;
  logic                   limit_stop;
  logic                   ramp_locked;

  modport source (output valid, output velocity_command, output limit_stop,
                  output ramp_locked, input ready);
  modport sink   (input valid, input velocity_command, input limit_stop,
                  input ramp_locked, output ready);
endinterface
`default_nettype wire

### rtl/core/first_order_regulator_ramp_limit.sv
// Top level: ramp-limited first-order regulator with position guard.
`default_nettype none
// One word in gives one command word out: the accept cycle forms the ramped
// reference and the error, then a sequencer drives one shared 20x18 signed
// multiplier five times (three gain products, then the two position
// predictions), rounds and saturates the sum, and checks the guard band. The
// block takes a new word only while the sequencer is idle, so it is through
// with one word before it takes the next. A finished command sits in an output
// register, so the next word is accepted while it waits; the sequencer holds in
// its last step if the previous command is still untaken. Configuration writes
// land at once and must be made while the block is idle.
module first_order_regulator_ramp_limit
  import frrl_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  frrl_in_if.sink                  in_i,
  frrl_out_if.source               out_o
);

  // configuration
  logic signed [RefW-1:0]  target_q, start_q, step_q, upper_q, lower_q;
  logic signed [GainW-1:0] c0_q, c1_q, c2_q;

  // regulator state
  logic signed [ErrW-1:0]  prev_e_q;
  logic signed [VelW-1:0]  prev_y_q;
  logic signed [OfsW-1:0]  offset_q;
  logic                    locked_q;

  // work registers
  state_e                  state_q;
  logic signed [ErrW-1:0]  e_q;
  logic signed [PosW-1:0]  pos_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q;
  logic signed [VelW-1:0]  y_q;
  logic                    stop_hi_q;

  // output register
  logic                    out_valid_q;
  logic signed [VelW-1:0]  out_vel_q;
  logic                    out_stop_q;
  logic                    out_locked_q;

  logic                    accept;
  logic signed [RampW-1:0] ref_sum, ofs_sum, ref_sel;
  logic                    lock_now;
  logic signed [RampW:0]   err_full;
  logic signed [VelW-1:0]  mul_a;
  logic signed [GainW-1:0] mul_b;
  logic signed [ProdW-1:0] prod_d;
  logic signed [VelW-1:0]  y_max, y_min;
  logic signed [AccW-1:0]  acc_rnd;
  logic signed [AccW-GainFrac-1:0] y_wide;
  logic signed [VelW-1:0]  y_sat;
  logic signed [ProdW-1:0] prod_rnd;
  logic signed [PredW-1:0] pred_pos;
  logic                    pred_over, pred_under, stop_all;
  logic                    out_free;

  function automatic logic signed [VelW-1:0] y_max_c();
    return {1'b0, {(VelW-1){1'b1}}};
  endfunction

  function automatic logic signed [VelW-1:0] y_min_c();
    return {1'b1, {(VelW-1){1'b0}}};
  endfunction

  assign accept    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign out_free  = !out_valid_q || out_o.ready;

  // reference ramp and error
  assign ref_sum = RampW'(start_q) + RampW'(offset_q);
  assign ofs_sum = RampW'(offset_q) + RampW'(step_q);
  assign lock_now = (ref_sum == RampW'(target_q)) ||
                    (step_q > 0 && ref_sum > RampW'(target_q)) ||
                    (step_q < 0 && ref_sum < RampW'(target_q));
  assign ref_sel  = (locked_q || lock_now) ? RampW'(target_q) : ref_sum;
  assign err_full = (RampW+1)'(ref_sel) - $signed({2'b00, in_i.measured_distance});

  // larger and smaller command for the guard
  assign y_max = (y_q > prev_y_q) ? y_q : prev_y_q;
  assign y_min = (y_q < prev_y_q) ? y_q : prev_y_q;

  // shared multiplier operands
  always_comb begin
    unique case (state_q)
      S_M0: begin
        mul_a = VelW'(e_q);
        mul_b = c0_q;
      end
      S_M1: begin
        mul_a = VelW'(prev_e_q);
        mul_b = c1_q;
      end
      S_M2: begin
        mul_a = prev_y_q;
        mul_b = c2_q;
      end
      S_PH: begin
        mul_a = y_max;
        mul_b = SamplePeriodQ16;
      end
      S_PL: begin
        mul_a = y_min;
        mul_b = SamplePeriodQ16;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod_d = mul_a * mul_b;

  // round half up and saturate the gain sum
  assign acc_rnd = acc_q + AccW'(1 << (GainFrac - 1));
  assign y_wide  = acc_rnd[AccW-1:GainFrac];
  always_comb begin
    if (y_wide > (AccW-GainFrac)'(signed'(y_max_c()))) begin
      y_sat = {1'b0, {(VelW-1){1'b1}}};
    end else if (y_wide < (AccW-GainFrac)'(signed'(y_min_c()))) begin
      y_sat = {1'b1, {(VelW-1){1'b0}}};
    end else begin
      y_sat = y_wide[VelW-1:0];
    end
  end

  // predicted position from the product held in prod_q
  assign prod_rnd  = prod_q + ProdW'(1 << (PerFrac - 1));
  assign pred_pos  = PredW'(pos_q) + PredW'($signed(prod_rnd[ProdW-1:PerFrac]));
  assign pred_over  = pred_pos > PredW'(upper_q);
  assign pred_under = pred_pos < PredW'(lower_q);
  assign stop_all   = stop_hi_q || pred_under;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= -16'sd800;
      start_q  <= '0;
      step_q   <= '0;
      c0_q     <= 18'sd37274;
      c1_q     <= -18'sd16253;
      c2_q     <= -18'sd2175;
      upper_q  <= 16'sd32767;
      lower_q  <= {1'b1, {(RefW-1){1'b0}}};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TARGET_REF: target_q <= cfg_data_i[RefW-1:0];
        CFG_START_REF:  start_q  <= cfg_data_i[RefW-1:0];
        CFG_RAMP_STEP:  step_q   <= cfg_data_i[RefW-1:0];
        CFG_GAIN_ERR:   c0_q     <= cfg_data_i[GainW-1:0];
        CFG_GAIN_PERR:  c1_q     <= cfg_data_i[GainW-1:0];
        CFG_GAIN_POUT:  c2_q     <= cfg_data_i[GainW-1:0];
        CFG_POS_UPPER:  upper_q  <= cfg_data_i[RefW-1:0];
        CFG_POS_LOWER:  lower_q  <= cfg_data_i[RefW-1:0];
      endcase
    end
  end

  // raise on a finished word, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      prev_e_q     <= '0;
      prev_y_q     <= '0;
      offset_q     <= '0;
      locked_q     <= 1'b0;
      e_q          <= '0;
      pos_q        <= '0;
      prod_q       <= '0;
      acc_q        <= '0;
      y_q          <= '0;
      stop_hi_q    <= 1'b0;
      out_vel_q    <= '0;
      out_stop_q   <= 1'b0;
      out_locked_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            e_q   <= err_full[ErrW-1:0];
            pos_q <= in_i.axis_position;
            if (!locked_q) begin
              if (lock_now) begin
                locked_q <= 1'b1;
              end else if (ofs_sum[RampW-1] != ofs_sum[RampW-2]) begin
                // saturate the ramp offset
                offset_q <= ofs_sum[RampW-1] ? {1'b1, {(OfsW-1){1'b0}}}
                                             : {1'b0, {(OfsW-1){1'b1}}};
              end else begin
                offset_q <= ofs_sum[OfsW-1:0];
              end
            end
            state_q <= S_M0;
          end
        end
        S_M0: begin
          prod_q  <= prod_d;
          state_q <= S_M1;
        end
        S_M1: begin
          acc_q   <= AccW'(prod_q);
          prod_q  <= prod_d;
          state_q <= S_M2;
        end
        S_M2: begin
          acc_q   <= acc_q + AccW'(prod_q);
          prod_q  <= prod_d;
          state_q <= S_ACC;
        end
        S_ACC: begin
          acc_q   <= acc_q + AccW'(prod_q);
          state_q <= S_SAT;
        end
        S_SAT: begin
          y_q     <= y_sat;
          state_q <= S_PH;
        end
        S_PH: begin
          prod_q  <= prod_d;
          state_q <= S_PL;
        end
        S_PL: begin
          stop_hi_q <= pred_over;
          prod_q    <= prod_d;
          state_q   <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (out_free) begin
            out_vel_q    <= stop_all ? '0 : y_q;
            out_stop_q   <= stop_all;
            out_locked_q <= locked_q;
            prev_e_q     <= e_q;
            prev_y_q     <= stop_all ? '0 : y_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.velocity_command = out_vel_q;
  assign out_o.limit_stop       = out_stop_q;
  assign out_o.ramp_locked      = out_locked_q;

`ifndef ASSERT_OFF
  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stop_q |-> out_vel_q == '0)
    else $error("stopped command is not zero");

  a_lock_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    locked_q |=> locked_q)
    else $error("ramp lock dropped");

  a_done_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE && out_free |=> out_valid_q && state_q == S_IDLE)
    else $error("finished word not written to output");

  a_prev_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE && out_free |=> prev_y_q == out_vel_q)
    else $error("stored previous output differs from issued command");
`endif

endmodule
`default_nettype wire

### verif/tb_first_order_regulator_ramp_limit.sv
// Testbench for the ramp-limited first-order regulator: random and directed samples checked against a predictor.
module tb_first_order_regulator_ramp_limit;
  import frrl_pkg::*;

  localparam int HoldLen     = 300;
  localparam int IdleLimit   = 3000;
  localparam int DrainCycles = 16;

  typedef struct packed {
    logic [DistW-1:0]       meas;
    logic signed [PosW-1:0] pos;
  } sample_t;

  typedef struct packed {
    logic signed [VelW-1:0] vel;
    logic                   stop;
    logic                   locked;
  } command_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  frrl_in_if  in_if ();
  frrl_out_if out_if ();

  first_order_regulator_ramp_limit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // regulator shadow: register file and state
  logic signed [RefW-1:0]  tgt_ref    = -16'sd800;
  logic signed [RefW-1:0]  start_ref  = 16'sd0;
  logic signed [RefW-1:0]  step_ref   = 16'sd0;
  logic signed [GainW-1:0] k_err      = 18'sd37274;
  logic signed [GainW-1:0] k_perr     = -18'sd16253;
  logic signed [GainW-1:0] k_pout     = -18'sd2175;
  logic signed [PosW-1:0]  pos_upper  = 16'sd32767;
  logic signed [PosW-1:0]  pos_lower  = -16'sd32768;
  logic signed [ErrW-1:0]  err_prev   = '0;
  logic signed [VelW-1:0]  cmd_prev   = '0;
  logic signed [OfsW-1:0]  ramp_ofs   = '0;
  logic                    ramp_is_locked = 1'b0;

  sample_t  sample_q[$];
  command_t cmd_q[$];

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;
  int hold_cnt;
  int n_errors;
  int n_cmds;
  int n_stops;
  int n_sat;
  int n_locked;
  int idle_cnt;

  function automatic longint round_q(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic command_t regulate_sample(sample_t s);
    longint   refv, e, acc, y, ymax, ymin, hi, lo, nxt;
    command_t r;
    if (ramp_is_locked) begin
      refv = tgt_ref;
    end else begin
      refv = longint'(start_ref) + longint'(ramp_ofs);
      if (refv == tgt_ref || (step_ref > 0 && refv > tgt_ref) ||
          (step_ref < 0 && refv < tgt_ref)) begin
        refv = tgt_ref;
        ramp_is_locked = 1'b1;
      end else begin
        nxt = longint'(ramp_ofs) + longint'(step_ref);
        if (nxt > 131071) nxt = 131071;
        if (nxt < -131072) nxt = -131072;
        ramp_ofs = nxt[OfsW-1:0];
      end
    end
    e = refv - longint'(s.meas);
    acc = longint'(k_err) * e + longint'(k_perr) * longint'(err_prev)
        + longint'(k_pout) * longint'(cmd_prev);
    y = round_q(acc, GainFrac);
    if (y > 524287) y = 524287;
    if (y < -524288) y = -524288;
    ymax = (y > cmd_prev) ? y : longint'(cmd_prev);
    ymin = (y < cmd_prev) ? y : longint'(cmd_prev);
    hi = longint'(s.pos) + round_q(ymax * 1311, PerFrac);
    lo = longint'(s.pos) + round_q(ymin * 1311, PerFrac);
    r.stop = (hi > pos_upper) || (lo < pos_lower);
    if (r.stop) y = 0;
    err_prev = e[ErrW-1:0];
    cmd_prev = y[VelW-1:0];
    r.vel    = y[VelW-1:0];
    r.locked = ramp_is_locked;
    return r;
  endfunction

  // driver: advance to the next pending word once the current one is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid             <= 1'b0;
      in_if.measured_distance <= '0;
      in_if.axis_position     <= '0;
    end else if (!in_if.valid || in_if.ready) begin
      if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_if.valid <= 1'b1;
        {in_if.measured_distance, in_if.axis_position} <= sample_q.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver: one long hold on request, random stalls otherwise
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      hold_cnt     <= 0;
    end else if (hold_req && hold_cnt < HoldLen) begin
      out_if.ready <= 1'b0;
      hold_cnt     <= hold_cnt + 1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: check taken commands first, then predict for the taken sample
  always @(posedge clk_i) begin
    command_t want, got;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.velocity_command, out_if.limit_stop, out_if.ramp_locked};
        if (cmd_q.size() == 0) begin
          $error("unexpected command word: vel %0d stop %0b locked %0b",
                 got.vel, got.stop, got.locked);
          n_errors++;
        end else begin
          want = cmd_q.pop_front();
          if (got.vel !== want.vel) begin
            $error("velocity_command: expected %0d, got %0d", want.vel, got.vel);
            n_errors++;
          end
          if (got.stop !== want.stop) begin
            $error("limit_stop: expected %0b, got %0b", want.stop, got.stop);
            n_errors++;
          end
          if (got.locked !== want.locked) begin
            $error("ramp_locked: expected %0b, got %0b", want.locked, got.locked);
            n_errors++;
          end
          n_cmds++;
          if (want.stop) n_stops++;
          if (want.vel == 20'sh7FFFF || want.vel == -20'sh80000) n_sat++;
          if (want.locked) n_locked++;
        end
      end
      if (in_if.valid && in_if.ready)
        cmd_q.push_back(regulate_sample('{in_if.measured_distance, in_if.axis_position}));
    end
  end

  // watchdog: drop the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        cfg_we_i) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= IdleLimit) begin
      $display("timeout: no word moved in %0d cycles", IdleLimit);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  task automatic write_reg(cfg_idx_e idx, int value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[CfgDataW-1:0];
    case (idx)
      CFG_TARGET_REF: tgt_ref   = value[RefW-1:0];
      CFG_START_REF:  start_ref = value[RefW-1:0];
      CFG_RAMP_STEP:  step_ref  = value[RefW-1:0];
      CFG_GAIN_ERR:   k_err     = value[GainW-1:0];
      CFG_GAIN_PERR:  k_perr    = value[GainW-1:0];
      CFG_GAIN_POUT:  k_pout    = value[GainW-1:0];
      CFG_POS_UPPER:  pos_upper = value[PosW-1:0];
      CFG_POS_LOWER:  pos_lower = value[PosW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_sample(int meas, int pos);
    sample_q.push_back('{meas[DistW-1:0], pos[PosW-1:0]});
  endtask

  // mostly plausible distances and positions, with full-range noise mixed in
  task automatic push_random(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0)
        push_sample($urandom_range(65535), $urandom_range(65535));
      else
        push_sample($urandom_range(4000), int'($urandom_range(4000)) - 2000);
    end
  endtask

  // wait until every word is delivered and checked, then let the block settle
  task automatic drain();
    @(negedge clk_i);
    while (sample_q.size() != 0 || cmd_q.size() != 0 || in_if.valid)
      @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    send_idle_pct = 17;
    recv_idle_pct = 59;
    hold_req      = 1'b0;
    n_errors      = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings, zero step, start off target: no lock
    push_sample(0, 0);
    push_sample(65535, 0);
    push_sample(0, 32767);
    push_sample(0, -32768);
    push_sample(65535, -32768);
    push_sample(65535, 32767);
    push_sample(16'h5555, 16'h2AAA);
    push_sample(16'hAAAA, -16'sh5556);
    push_sample(800, 0);
    push_sample(1, -1);
    push_sample(32768, 100);
    push_sample(0, 32000);
    push_sample(65535, -32000);
    hold_req <= 1'b1;
    push_random(250);
    drain();

    // extreme gains, tight band, start at the top
    write_reg(CFG_GAIN_ERR, 131071);
    write_reg(CFG_GAIN_PERR, -131072);
    write_reg(CFG_GAIN_POUT, 131071);
    write_reg(CFG_POS_UPPER, 100);
    write_reg(CFG_POS_LOWER, -100);
    write_reg(CFG_START_REF, 32767);
    push_random(125);
    drain();
    push_random(125);
    drain();

    // inverted band: every command stops
    send_idle_pct = 59;
    recv_idle_pct = 17;
    write_reg(CFG_GAIN_ERR, -131072);
    write_reg(CFG_GAIN_PERR, 131071);
    write_reg(CFG_GAIN_POUT, -131072);
    write_reg(CFG_POS_UPPER, -32768);
    write_reg(CFG_POS_LOWER, 32767);
    push_random(150);
    drain();

    // downward ramp that overshoots the target and locks
    write_reg(CFG_GAIN_ERR, 37274);
    write_reg(CFG_GAIN_PERR, -16253);
    write_reg(CFG_GAIN_POUT, -2175);
    write_reg(CFG_POS_UPPER, 20000);
    write_reg(CFG_POS_LOWER, -20000);
    write_reg(CFG_START_REF, 2000);
    write_reg(CFG_TARGET_REF, -800);
    write_reg(CFG_RAMP_STEP, -37);
    push_random(300);
    drain();

    // locked: new target applies, start and step no longer matter
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_TARGET_REF, 32767);
    write_reg(CFG_START_REF, -32768);
    write_reg(CFG_RAMP_STEP, 32767);
    write_reg(CFG_GAIN_ERR, 4096);
    write_reg(CFG_GAIN_PERR, 0);
    write_reg(CFG_GAIN_POUT, 2048);
    write_reg(CFG_POS_UPPER, 32767);
    write_reg(CFG_POS_LOWER, -32768);
    push_random(250);
    drain();

    write_reg(CFG_TARGET_REF, -32768);
    write_reg(CFG_RAMP_STEP, -32768);
    write_reg(CFG_GAIN_ERR, 1);
    write_reg(CFG_GAIN_PERR, -1);
    write_reg(CFG_GAIN_POUT, 0);
    push_random(250);
    drain();

    $display("checked %0d command words over six register settings and both ramp states",
             n_cmds);
    $display("%0d guard stops, %0d saturated commands, %0d words after ramp lock",
             n_stops, n_sat, n_locked);
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
